/* rtl/core/mlfq_pkg.sv */
// ----------------------------------------------------------------------------
// mlfq_pkg
// Shared types, codes and helpers for the feedback-queue task scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package mlfq_pkg;

    localparam int NUM_SLOTS  = 64;
    localparam int NUM_LEVELS = 5;
    localparam int SLOT_W     = $clog2(NUM_SLOTS);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [2:0] ST_UNUSED   = 3'd0;
    localparam logic [2:0] ST_EMBRYO   = 3'd1;
    localparam logic [2:0] ST_SLEEPING = 3'd2;
    localparam logic [2:0] ST_RUNNABLE = 3'd3;
    localparam logic [2:0] ST_RUNNING  = 3'd4;
    localparam logic [2:0] ST_EXITED   = 3'd5;

    localparam logic [1:0] NS_RUNNABLE = 2'd0;
    localparam logic [1:0] NS_SLEEPING = 2'd1;

    localparam logic [2:0] TOP_LEVEL = 3'(NUM_LEVELS - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_AGE_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM0  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM4  = 3'd5;

    typedef enum logic [2:0] {
        K_TICK   = 3'd0,
        K_CREATE = 3'd1,
        K_WAKE   = 3'd2,
        K_SCHED  = 3'd3,
        K_RETURN = 3'd4,
        K_REAP   = 3'd5,
        K_QUERY  = 3'd6,
        K_NONE   = 3'd7
    } kind_t;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_READ,
        SQ_PROC,
        SQ_GRANT_RD,
        SQ_GRANT,
        SQ_DONE
    } seq_state_t;

    typedef struct packed {
        logic [15:0]                 age_limit;
        logic [NUM_LEVELS-1:0][7:0]  quantum;
    } cfg_t;

    typedef struct packed {
        kind_t       kind;
        logic [5:0]  slot;
        logic [1:0]  new_state;
        logic [7:0]  wait_channel;
        logic [2:0]  query_level;
    } item_t;

    typedef struct packed {
        logic [2:0]                   state;
        logic [2:0]                   level;
        logic [7:0]                   slice;
        logic [31:0]                  stamp;
        logic [31:0]                  ran;
        logic [31:0]                  slept;
        logic [31:0]                  disp;
        logic [7:0]                   chan;
        logic [NUM_LEVELS-1:0][31:0]  lvl_ticks;
    } rec_t;

    typedef struct packed {
        logic [31:0] level_ticks;
        logic [31:0] wait_ticks;
        logic [31:0] run_count;
        logic [31:0] io_ticks;
        logic [31:0] run_ticks;
        logic [2:0]  task_level;
        logic [2:0]  task_state;
        logic        redispatch;
        logic [31:0] new_pid;
        logic        ok;
        logic [5:0]  chosen_slot;
    } res_t;

    function automatic res_t report(rec_t r, logic [SLOT_W-1:0] idx, logic [31:0] tick);
        res_t res;
        res             = '0;
        res.chosen_slot = 6'(idx);
        res.ok          = 1'b1;
        res.task_state  = r.state;
        res.task_level  = r.level;
        res.run_ticks   = r.ran;
        res.io_ticks    = r.slept;
        res.run_count   = r.disp;
        res.wait_ticks  = tick - r.stamp;
        return res;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/mlfq_slot_ram.sv */
// ----------------------------------------------------------------------------
// mlfq_slot_ram
// Task slot table: one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mlfq_slot_ram
    import mlfq_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [SLOT_W-1:0] wr_addr,
    input  wire rec_t              wr_data,
    input  wire logic [SLOT_W-1:0] rd_addr,
    output rec_t                   rd_data
);

    rec_t mem [NUM_SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

/* rtl/core/mlfq_seq.sv */
// ----------------------------------------------------------------------------
// mlfq_seq
// Slot-walking sequencer with the shared per-slot update and compare unit.
// ----------------------------------------------------------------------------
`default_nettype none

module mlfq_seq
    import mlfq_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  start,
    input  wire item_t item,
    output logic       idle,
    output logic       done,
    output res_t       result,
    input  wire logic  taken
);

    seq_state_t state_reg, state_next;
    item_t item_reg, item_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic [31:0] tick_reg, tick_next;
    logic [31:0] id_reg, id_next;
    logic [NUM_SLOTS-1:0] valid_reg, valid_next;
    logic found_reg, found_next;
    logic [SLOT_W-1:0] best_idx_reg, best_idx_next;
    logic [34:0] best_key_reg, best_key_next;
    res_t res_reg, res_next;

    logic wr_en;
    rec_t wr_data, rd_data, cur, upd;
    logic [SLOT_W-1:0] rd_addr;
    logic last;
    logic [7:0] q;
    logic [2:0] qsel;
    logic [34:0] key;

    mlfq_slot_ram u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (idx_reg),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SQ_IDLE;
            tick_reg  <= '0;
            id_reg    <= 32'd1;
            valid_reg <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tick_reg  <= tick_next;
            id_reg    <= id_next;
            valid_reg <= valid_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        idx_reg      <= idx_next;
        best_idx_reg <= best_idx_next;
        best_key_reg <= best_key_next;
        res_reg      <= res_next;
    end

    assign idle   = (state_reg == SQ_IDLE);
    assign done   = (state_reg == SQ_DONE);
    assign result = res_reg;
    assign last   = (idx_reg == SLOT_W'(NUM_SLOTS - 1));

    always_comb
    begin
        cur = rd_data;
        if (!valid_reg[idx_reg])
        begin
            cur.state = ST_UNUSED;
        end
        qsel = (cur.level < 3'(NUM_LEVELS)) ? cur.level : TOP_LEVEL;
        q    = cfg.quantum[qsel];
        key  = '0;

        state_next    = state_reg;
        item_next     = item_reg;
        idx_next      = idx_reg;
        tick_next     = tick_reg;
        id_next       = id_reg;
        valid_next    = valid_reg;
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_key_next = best_key_reg;
        res_next      = res_reg;
        rd_addr       = idx_reg;
        wr_en         = 1'b0;
        upd           = cur;
        wr_data       = cur;

        case (state_reg)
            SQ_IDLE:
            begin
                if (start)
                begin
                    item_next  = item;
                    res_next   = '0;
                    found_next = 1'b0;
                    case (item.kind)
                        K_TICK, K_CREATE, K_WAKE, K_SCHED:
                        begin
                            idx_next   = '0;
                            state_next = SQ_READ;
                            if (item.kind == K_TICK)
                            begin
                                tick_next = tick_reg + 32'd1;
                            end
                        end
                        K_RETURN, K_REAP, K_QUERY:
                        begin
                            idx_next = SLOT_W'(item.slot);
                            if (32'(item.slot) < NUM_SLOTS)
                            begin
                                state_next = SQ_READ;
                            end
                            else
                            begin
                                state_next = SQ_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = SQ_DONE;
                        end
                    endcase
                end
            end

            SQ_READ:
            begin
                state_next = SQ_PROC;
            end

            SQ_PROC:
            begin
                state_next = last ? SQ_DONE : SQ_READ;
                idx_next   = idx_reg + SLOT_W'(1);
                case (item_reg.kind)
                    K_TICK:
                    begin
                        if (cur.state == ST_RUNNING)
                        begin
                            upd.ran   = cur.ran + 32'd1;
                            upd.stamp = tick_reg;
                            if (cur.slice != 8'hFF)
                            begin
                                upd.slice = cur.slice + 8'd1;
                            end
                            for (int l = 0; l < NUM_LEVELS; l++)
                            begin
                                if (cur.level == 3'(l))
                                begin
                                    upd.lvl_ticks[l] = cur.lvl_ticks[l] + 32'd1;
                                end
                            end
                            wr_en = 1'b1;
                        end
                        else if (cur.state == ST_SLEEPING)
                        begin
                            upd.slept = cur.slept + 32'd1;
                            upd.stamp = tick_reg;
                            wr_en     = 1'b1;
                        end
                        if (last)
                        begin
                            res_next.ok = 1'b1;
                        end
                    end
                    K_CREATE:
                    begin
                        if (cur.state == ST_UNUSED)
                        begin
                            upd       = '0;
                            upd.state = ST_RUNNABLE;
                            upd.stamp = tick_reg;
                            wr_en     = 1'b1;
                            valid_next[idx_reg] = 1'b1;
                            res_next  = report(upd, idx_reg, tick_reg);
                            res_next.new_pid = id_reg;
                            id_next    = id_reg + 32'd1;
                            state_next = SQ_DONE;
                        end
                    end
                    K_WAKE:
                    begin
                        if (cur.state == ST_SLEEPING && cur.chan == item_reg.wait_channel)
                        begin
                            upd.state   = ST_RUNNABLE;
                            wr_en       = 1'b1;
                            res_next.ok = 1'b1;
                        end
                    end
                    K_SCHED:
                    begin
                        if (cur.state == ST_RUNNABLE)
                        begin
                            if ((tick_reg - cur.stamp) > 32'(cfg.age_limit) &&
                                cur.level != 3'd0)
                            begin
                                upd.level = cur.level - 3'd1;
                                upd.slice = 8'd0;
                                upd.stamp = tick_reg;
                                wr_en     = 1'b1;
                            end
                            key = {upd.level, upd.stamp};
                            if (!found_reg || key < best_key_reg)
                            begin
                                found_next    = 1'b1;
                                best_key_next = key;
                                best_idx_next = idx_reg;
                            end
                        end
                        if (last && (found_next))
                        begin
                            state_next = SQ_GRANT_RD;
                        end
                    end
                    K_RETURN:
                    begin
                        state_next = SQ_DONE;
                        if (cur.state == ST_RUNNING)
                        begin
                            wr_en = 1'b1;
                            if (item_reg.new_state == NS_RUNNABLE && cur.slice < q)
                            begin
                                res_next = report(cur, idx_reg, tick_reg);
                                res_next.redispatch = 1'b1;
                            end
                            else
                            begin
                                if (item_reg.new_state == NS_RUNNABLE)
                                begin
                                    upd.state = ST_RUNNABLE;
                                end
                                else if (item_reg.new_state == NS_SLEEPING)
                                begin
                                    upd.state = ST_SLEEPING;
                                    upd.chan  = item_reg.wait_channel;
                                end
                                else
                                begin
                                    upd.state = ST_EXITED;
                                end
                                if (cur.slice >= q)
                                begin
                                    if (cur.level < TOP_LEVEL && upd.state != ST_EXITED)
                                    begin
                                        upd.level = cur.level + 3'd1;
                                    end
                                    upd.slice = 8'd0;
                                end
                                upd.disp  = cur.disp + 32'd1;
                                upd.stamp = tick_reg;
                                res_next  = report(upd, idx_reg, tick_reg);
                            end
                        end
                    end
                    K_REAP:
                    begin
                        state_next = SQ_DONE;
                        if (cur.state == ST_EXITED)
                        begin
                            upd.state            = ST_UNUSED;
                            wr_en                = 1'b1;
                            res_next.ok          = 1'b1;
                            res_next.chosen_slot = 6'(idx_reg);
                        end
                    end
                    K_QUERY:
                    begin
                        state_next = SQ_DONE;
                        if (cur.state != ST_UNUSED)
                        begin
                            res_next = report(cur, idx_reg, tick_reg);
                            if (item_reg.query_level < 3'(NUM_LEVELS))
                            begin
                                res_next.level_ticks = cur.lvl_ticks[item_reg.query_level];
                            end
                        end
                    end
                    default:
                    begin
                        state_next = SQ_DONE;
                    end
                endcase
                wr_data = upd;
            end

            SQ_GRANT_RD:
            begin
                idx_next   = best_idx_reg;
                rd_addr    = best_idx_reg;
                state_next = SQ_GRANT;
            end

            SQ_GRANT:
            begin
                upd.slice = 8'd0;
                upd.state = ST_RUNNING;
                wr_en     = 1'b1;
                wr_data   = upd;
                res_next  = report(upd, idx_reg, tick_reg);
                state_next = SQ_DONE;
            end

            SQ_DONE:
            begin
                if (taken)
                begin
                    state_next = SQ_IDLE;
                end
            end

            default:
            begin
                state_next = SQ_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/mlfq_process_scheduler.sv */
// ----------------------------------------------------------------------------
// mlfq_process_scheduler
// Five-level feedback-queue task scheduler over a table of task slots.
// ----------------------------------------------------------------------------
// Tick, wake and schedule walk all slots, reading and then processing each one;
// create walks until it finds a free slot; return, reap and query visit one slot.
// The slot table has separate read and write ports; one item is in work at a time.
// A finished result waits in an output register while the next item is taken.
// Reset clears the tick count, marks every slot unused and loads the default
// configuration; no clearing pass is needed.
`default_nettype none

module mlfq_process_scheduler
    import mlfq_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // slot[5:0], new_state[7:6], wait_channel[15:8], query_level[18:16], zeros
    input  wire logic [23:0]           s_tdata,
    // kind[2:0]
    input  wire logic [2:0]            s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // chosen_slot[5:0], ok[6], new_pid[38:7], redispatch[39], task_state[42:40],
    // task_level[45:43], run_ticks[77:46], io_ticks[109:78], run_count[141:110],
    // wait_ticks[173:142], level_ticks[205:174], zeros
    output logic [207:0]               m_tdata,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg_reg, cfg_next;
    logic out_valid_reg, out_valid_next;
    res_t out_reg, out_next;
    item_t item;
    res_t result;
    logic idle, done, taken;

    assign cfg_ready = 1'b1;
    assign s_tready  = idle;

    always_comb
    begin
        item.kind         = kind_t'(s_tuser);
        item.slot         = s_tdata[5:0];
        item.new_state    = s_tdata[7:6];
        item.wait_channel = s_tdata[15:8];
        item.query_level  = s_tdata[18:16];
    end

    mlfq_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .start  (s_tvalid),
        .item   (item),
        .idle   (idle),
        .done   (done),
        .result (result),
        .taken  (taken)
    );

    assign taken = done && (!out_valid_reg || m_tready);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            if (cfg_index == CFG_AGE_LIMIT)
            begin
                cfg_next.age_limit = cfg_data;
            end
            else if (cfg_index >= CFG_QUANTUM0 && cfg_index <= CFG_QUANTUM4)
            begin
                cfg_next.quantum[cfg_index - CFG_QUANTUM0] = cfg_data[7:0];
            end
        end

        out_valid_next = out_valid_reg && !m_tready;
        out_next       = out_reg;
        if (taken)
        begin
            out_valid_next = 1'b1;
            out_next       = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.age_limit  <= 16'd25;
            cfg_reg.quantum[0] <= 8'd1;
            cfg_reg.quantum[1] <= 8'd2;
            cfg_reg.quantum[2] <= 8'd4;
            cfg_reg.quantum[3] <= 8'd8;
            cfg_reg.quantum[4] <= 8'd16;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg};

endmodule

`default_nettype wire
